@@ rtl/core/gtg_pkg.sv @@
`timescale 1ns / 1ps
package gtg_pkg;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned CordicIdxW  = 5;
  localparam int unsigned CordicW     = 34;
  localparam int unsigned SqrtSteps   = 9;
  localparam int unsigned SqrtIdxW    = 4;
  localparam int unsigned StepLin     = 50;
  localparam int unsigned StepAng     = 175;
  localparam int unsigned MaxLin      = 250;
  localparam int unsigned MinLin      = 100;
  localparam int unsigned MaxAng      = 628;
  localparam int unsigned MinAng      = 87;
  localparam int unsigned BandPos     = 91;
  localparam int unsigned BandHdg     = 182;
  localparam int unsigned StopD2      = 625;
  localparam int unsigned FastD2      = 62500;

  typedef enum logic [1:0] {
    REG_GOAL_X   = 2'd0,
    REG_GOAL_Y   = 2'd1,
    REG_GOAL_HDG = 2'd2,
    REG_MODE     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [15:0]        goal_heading;
    logic               drive_mode;
  } cfg_t;

  function automatic logic [31:0] atan_lut(input logic [CordicIdxW-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage

@@ rtl/core/gtg_if.sv @@
`timescale 1ns / 1ps
interface gtg_in_if;
  logic               valid;
  logic               ready;
  logic               start_req;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic [15:0]        heading;
  modport source (output valid, start_req, pose_x, pose_y, heading, input ready);
  modport sink (input valid, start_req, pose_x, pose_y, heading, output ready);
endinterface

interface gtg_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         linear_speed;
  logic signed [10:0] angular_speed;
  logic               busy_res;
  modport source (output valid, linear_speed, angular_speed, busy_res, input ready);
  modport sink (input valid, linear_speed, angular_speed, busy_res, output ready);
endinterface

interface gtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/go_to_goal_drive_controller.sv @@
`timescale 1ns / 1ps
// Proportional go-to-goal drive controller. Each input request is one control
// tick carrying the pose; each tick returns exactly one slew-limited speed
// pair and a busy flag. The input is not ready while a tick is worked on.
// In position mode a tick runs the squared distance, the bearing by 20 CORDIC
// rotations, the 9-step square root, the turn multiply, the turn limit and
// slew, then the output; the turn limit is skipped when the error is inside
// the deadband. Inside the stop radius the tick waits out the CORDIC and goes
// to the slew; heading mode runs only the turn and the slew, and while not
// controlling only the slew runs. The result is held until it is taken.
// Goal and mode registers are read live on every tick, so write them only
// between ticks.
module go_to_goal_drive_controller (
  input  logic   clk_i,
  input  logic   rst_ni,
  gtg_in_if.sink    in_if,
  gtg_out_if.source out_if,
  gtg_cfg_if.sink   cfg_if
);
  import gtg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_CORDIC, S_SQRT, S_TURN, S_SLEW, S_OUT
  } state_e;

  state_e state_q;
  cfg_t cfg_q;
  logic ctl_q;
  logic [7:0] lin_q;
  logic signed [10:0] ang_q;
  logic signed [16:0] dx_q, dy_q;
  logic [15:0] cur_q;
  logic [33:0] d2_q;
  logic [15:0] bear_q;
  logic [8:0] vt_q;
  logic signed [10:0] wt_q;
  logic [31:0] prod_q;
  logic sq_ph_q;
  logic turn_ph_q;
  logic [16:0] ea_q;
  logic eneg_q;

  // configuration writes
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_if.valid) begin
      case (reg_idx_e'(cfg_if.index))
        REG_GOAL_X:   cfg_q.goal_x <= cfg_if.data;
        REG_GOAL_Y:   cfg_q.goal_y <= cfg_if.data;
        REG_GOAL_HDG: cfg_q.goal_heading <= cfg_if.data;
        REG_MODE:     cfg_q.drive_mode <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // bearing and square-root units
  logic cd_start, cd_done, sq_start, sq_done;
  logic [15:0] cd_bear;
  logic [8:0] sq_root;
  gtg_cordic u_cordic (.clk_i, .rst_ni, .start_i(cd_start), .dx_i(dx_q), .dy_i(dy_q),
                       .done_o(cd_done), .bearing_o(cd_bear));
  gtg_isqrt u_isqrt (.clk_i, .rst_ni, .start_i(sq_start), .v_i(d2_q[16:0]),
                     .done_o(sq_done), .root_o(sq_root));

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  assign mul_p = mul_a * mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQ) begin
      mul_a = sq_ph_q ? 18'(dy_q) : 18'(dx_q);
      mul_b = mul_a;
    end else if (state_q == S_TURN) begin
      mul_a = 18'(ea_q);
      mul_b = cfg_q.drive_mode ? 18'sd12566 : 18'sd6283;
    end
  end

  // heading error of target vs current
  logic [15:0] tgt, ediff;
  assign tgt   = cfg_q.drive_mode ? bear_q : cfg_q.goal_heading;
  assign ediff = tgt - cur_q;

  // slew targets
  logic signed [11:0] dl, da;
  logic [7:0] lin_n;
  logic signed [10:0] ang_n;
  logic [8:0] vt_c;
  assign vt_c = vt_q;
  assign dl = 12'($signed({3'b0, vt_c})) - 12'($signed({4'b0, lin_q}));
  assign da = 12'(wt_q) - 12'(ang_q);
  always_comb begin
    if (dl < 12'sd50 && dl > -12'sd50) lin_n = vt_c[7:0];
    else if (dl > 0) lin_n = lin_q + 8'(StepLin);
    else lin_n = lin_q - 8'(StepLin);
    if (da < 12'sd175 && da > -12'sd175) ang_n = wt_q;
    else if (da > 0) ang_n = ang_q + 11'sd175;
    else ang_n = ang_q - 11'sd175;
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.linear_speed = lin_q;
  assign out_if.angular_speed = ang_q;
  assign out_if.busy_res = ctl_q;
  assign cd_start = (state_q == S_SQ) && sq_ph_q && ctl_q && cfg_q.drive_mode;
  assign sq_start = cd_done;

  logic [16:0] mag_r;
  logic [15:0] band;
  assign mag_r = 17'((prod_q + 32'd32768) >> 16);
  assign band = cfg_q.drive_mode ? 16'(BandPos) : 16'(BandHdg);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ctl_q     <= 1'b0;
      lin_q     <= '0;
      ang_q     <= '0;
      sq_ph_q   <= 1'b0;
      turn_ph_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (in_if.valid) begin
          ctl_q   <= ctl_q | in_if.start_req;
          dx_q    <= 17'(cfg_q.goal_x) - 17'(in_if.pose_x);
          dy_q    <= 17'(cfg_q.goal_y) - 17'(in_if.pose_y);
          cur_q   <= in_if.heading;
          vt_q    <= '0;
          wt_q    <= '0;
          sq_ph_q <= 1'b0;
          turn_ph_q <= 1'b0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (!(ctl_q | 1'b0)) begin
            state_q <= S_SLEW;
          end else if (!cfg_q.drive_mode) begin
            state_q <= S_TURN;
          end else if (!sq_ph_q) begin
            d2_q    <= 34'(mul_p);
            sq_ph_q <= 1'b1;
          end else begin
            d2_q <= d2_q + 34'(mul_p);
            state_q <= S_CORDIC;
          end
        end
        S_CORDIC: if (d2_q <= 34'(StopD2)) begin
          // stop zone waits out the cordic but ignores it
          if (cd_done) state_q <= S_SLEW;
        end else if (cd_done) begin
          bear_q  <= cd_bear;
          state_q <= S_SQRT;
        end
        S_SQRT: if (sq_done) begin
          if (d2_q > 34'(FastD2)) vt_q <= 9'(MaxLin);
          else if ((sq_root >> 1) < 9'(MinLin)) vt_q <= 9'(MinLin);
          else vt_q <= sq_root >> 1;
          state_q <= S_TURN;
        end
        S_TURN: begin
          if (!turn_ph_q) begin
            if (ediff[15] && ediff != 16'h8000) begin
              ea_q <= {1'b0, -ediff};
              eneg_q <= 1'b1;
            end else begin
              ea_q <= {1'b0, ediff};
              eneg_q <= 1'b0;
            end
            turn_ph_q <= 1'b1;
          end else if (ea_q <= 17'(band)) begin
            wt_q <= '0;
            state_q <= S_SLEW;
          end else begin
            prod_q <= 32'(mul_p);
            state_q <= S_SLEW;
          end
        end
        S_SLEW: begin
          if (turn_ph_q && prod_q != 32'd0 && wt_q == 11'sd0 && ea_q > 17'(band)) begin
            // finish the turn magnitude from the registered product
            if (mag_r > 17'(MaxAng))
              wt_q <= eneg_q ? -11'sd628 : 11'sd628;
            else if (mag_r < 17'(MinAng))
              wt_q <= eneg_q ? -11'sd87 : 11'sd87;
            else
              wt_q <= eneg_q ? -11'(mag_r) : 11'(mag_r);
            prod_q <= '0;
          end else begin
            if (ctl_q && vt_q == 9'd0 && wt_q == 11'sd0) ctl_q <= 1'b0;
            lin_q   <= lin_n;
            ang_q   <= ang_n;
            state_q <= S_OUT;
          end
        end
        S_OUT: if (out_if.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/gtg_cordic.sv @@
`timescale 1ns / 1ps
module gtg_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] dx_i,
  input  logic signed [16:0] dy_i,
  output logic               done_o,
  output logic [15:0]        bearing_o
);
  import gtg_pkg::*;

  logic signed [CordicW-1:0] x_q, y_q;
  logic [31:0] z_q;
  logic [CordicIdxW-1:0] i_q;
  logic run_q;
  logic signed [CordicW-1:0] xs, ys, x0, y0;
  logic [31:0] a;

  // shifted operands, arithmetic shift equals floor division
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign a  = atan_lut(i_q);
  assign x0 = CordicW'(dx_i) <<< 12;
  assign y0 = CordicW'(dy_i) <<< 12;

  // one rotation per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      i_q    <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= '0;
        if (dx_i < 0) begin
          x_q <= -x0;
          y_q <= -y0;
          z_q <= 32'h8000_0000;
        end else begin
          x_q <= x0;
          y_q <= y0;
          z_q <= '0;
        end
      end else if (run_q) begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + a;
        end else if (y_q < 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - a;
        end
        if (i_q == CordicIdxW'(CordicSteps - 1)) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
        i_q <= i_q + 1'b1;
      end
    end
  end

  logic [31:0] zr;
  assign zr = z_q + 32'h8000;
  assign bearing_o = zr[31:16];
endmodule

@@ rtl/core/gtg_isqrt.sv @@
`timescale 1ns / 1ps
module gtg_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] v_i,
  output logic        done_o,
  output logic [8:0]  root_o
);
  import gtg_pkg::*;

  // restoring square root, one result bit per cycle
  logic [17:0] rem_q;
  logic [8:0]  root_q;
  logic [17:0] v_q;
  logic [SqrtIdxW-1:0] n_q;
  logic run_q;
  logic [17:0] trial;
  logic [17:0] rem_sh;

  assign rem_sh = {rem_q[15:0], v_q[17:16]};
  assign trial  = {7'd0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      n_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        rem_q  <= '0;
        root_q <= '0;
        // radicand padded to an even bit count so pairs line up
        v_q    <= {1'b0, v_i};
        n_q    <= '0;
      end else if (run_q) begin
        v_q <= {v_q[15:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[7:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[7:0], 1'b0};
        end
        if (n_q == SqrtIdxW'(SqrtSteps - 1)) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
        n_q <= n_q + 1'b1;
      end
    end
  end

  assign root_o = root_q;
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import gtg_pkg::*;

  typedef struct packed {
    logic               start_req;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic [15:0]        heading;
  } tick_t;

  typedef struct packed {
    logic [7:0]         linear_speed;
    logic signed [10:0] angular_speed;
    logic               busy_res;
  } drive_cmd_t;

  localparam int unsigned SettleCycles = 60;

  logic clk_i;
  logic rst_ni;

  gtg_in_if  in_if ();
  gtg_out_if out_if ();
  gtg_cfg_if cfg_if ();

  go_to_goal_drive_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  tick_t      pending_ticks[$];
  drive_cmd_t expected_cmds[$];
  int         mismatches;
  logic       tick_taken;
  logic       steady;
  int         hold_left;

  // mirror of the goal registers and controller state
  logic signed [15:0] m_goal_x, m_goal_y;
  logic [15:0]        m_goal_hdg;
  logic               m_mode;
  logic               m_active;
  int                 m_last_lin, m_last_ang;

  localparam int unsigned ATAN_STEP[20] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };

  // bearing to goal as 16-bit binary angle, vectoring rotations
  function automatic logic [15:0] goal_bearing(int dx, int dy);
    longint      x, y, xs, ys;
    logic [31:0] z;
    x = longint'(dx) * 4096;
    y = longint'(dy) * 4096;
    z = 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  function automatic int wrap_error(logic [15:0] target, logic [15:0] cur);
    logic [15:0] d;
    int          e;
    d = target - cur;
    e = int'($signed(d));
    if (e == -32768) e = 32768;
    return e;
  endfunction

  function automatic int turn_rate(int e, int unsigned kp, int band);
    int unsigned a, mag;
    a = (e < 0) ? -e : e;
    if (int'(a) <= band) return 0;
    mag = (kp * a * 6283 + 32768) >> 16;
    if (mag > MaxAng) mag = MaxAng;
    else if (mag < MinAng) mag = MinAng;
    return (e < 0) ? -int'(mag) : int'(mag);
  endfunction

  function automatic int slew_toward(int target, int last, int step);
    int d;
    d = target - last;
    if (d < step && d > -step) return target;
    return (d > 0) ? last + step : last - step;
  endfunction

  // one control tick against the mirrored state
  function automatic drive_cmd_t control_tick(tick_t t);
    int          v_t, w_t, dx, dy, r;
    longint      d2;
    drive_cmd_t  c;
    v_t = 0;
    w_t = 0;
    if (t.start_req) m_active = 1'b1;
    if (m_active) begin
      if (m_mode) begin
        dx = int'(m_goal_x) - int'(t.pose_x);
        dy = int'(m_goal_y) - int'(t.pose_y);
        d2 = longint'(dx) * dx + longint'(dy) * dy;
        if (d2 > StopD2) begin
          w_t = turn_rate(wrap_error(goal_bearing(dx, dy), t.heading), 2, BandPos);
          if (d2 > FastD2) begin
            v_t = MaxLin;
          end else begin
            r = 0;
            while (longint'(r + 1) * (r + 1) <= d2) r++;
            v_t = r >> 1;
            if (v_t < MinLin) v_t = MinLin;
          end
        end
      end else begin
        w_t = turn_rate(wrap_error(m_goal_hdg, t.heading), 1, BandHdg);
      end
      if (v_t == 0 && w_t == 0) m_active = 1'b0;
    end
    m_last_lin = slew_toward(v_t, m_last_lin, StepLin);
    m_last_ang = slew_toward(w_t, m_last_ang, StepAng);
    c.linear_speed  = m_last_lin[7:0];
    c.angular_speed = m_last_ang[10:0];
    c.busy_res      = m_active;
    return c;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // tick driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.start_req <= 1'b0;
      in_if.pose_x    <= '0;
      in_if.pose_y    <= '0;
      in_if.heading   <= '0;
    end else if (!in_if.valid || tick_taken) begin
      if (pending_ticks.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
        tick_t t;
        t = pending_ticks.pop_front();
        in_if.valid     <= 1'b1;
        in_if.start_req <= t.start_req;
        in_if.pose_x    <= t.pose_x;
        in_if.pose_y    <= t.pose_y;
        in_if.heading   <= t.heading;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  // monitor: predict on accepted ticks, check accepted results
  always @(posedge clk_i) begin
    tick_taken <= in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (reg_idx_e'(cfg_if.index))
          REG_GOAL_X:   m_goal_x   <= cfg_if.data;
          REG_GOAL_Y:   m_goal_y   <= cfg_if.data;
          REG_GOAL_HDG: m_goal_hdg <= cfg_if.data;
          REG_MODE:     m_mode     <= cfg_if.data[0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        expected_cmds.insert(expected_cmds.size(),
                             control_tick({in_if.start_req, in_if.pose_x,
                                           in_if.pose_y, in_if.heading}));
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result lin=%0d ang=%0d busy=%0b",
                                         out_if.linear_speed, out_if.angular_speed,
                                         out_if.busy_res);
        end else begin
          drive_cmd_t e;
          e = expected_cmds.pop_front();
          if (e.linear_speed !== out_if.linear_speed ||
              e.angular_speed !== out_if.angular_speed ||
              e.busy_res !== out_if.busy_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected lin=%0d ang=%0d busy=%0b, got lin=%0d ang=%0d busy=%0b",
                       e.linear_speed, e.angular_speed, e.busy_res, out_if.linear_speed,
                       out_if.angular_speed, out_if.busy_res);
          end
        end
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_goal(logic [15:0] gx, logic [15:0] gy, logic [15:0] gh, logic mode);
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_GOAL_HDG, gh);
    write_reg(REG_MODE, {15'd0, mode});
  endtask

  task automatic add_tick(logic s, logic [15:0] px, logic [15:0] py, logic [15:0] h);
    pending_ticks.insert(pending_ticks.size(), {s, px, py, h});
  endtask

  // sender pause until every result is back, then let the block settle
  task automatic drain();
    wait (pending_ticks.size() == 0 && expected_cmds.size() == 0 && !in_if.valid);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // random ticks around the goal, occasionally anywhere
  task automatic random_ticks(int n, logic signed [15:0] gx, logic signed [15:0] gy);
    int span, px, py;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        px = $urandom_range(65535);
        py = $urandom_range(65535);
      end else begin
        span = ($urandom_range(3) == 0) ? 40 : 400;
        px = int'(gx) + $urandom_range(2 * span) - span;
        py = int'(gy) + $urandom_range(2 * span) - span;
      end
      add_tick($urandom_range(7) == 0, px[15:0], py[15:0], 16'($urandom_range(65535)));
    end
  endtask

  initial begin
    logic signed [15:0] gx, gy;
    mismatches   = 0;
    steady       = 1'b0;
    hold_left    = 0;
    tick_taken   = 1'b0;
    m_goal_x     = '0;
    m_goal_y     = '0;
    m_goal_hdg   = '0;
    m_mode       = 1'b0;
    m_active     = 1'b0;
    m_last_lin   = 0;
    m_last_ang   = 0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_GOAL_X;
    cfg_if.data  = '0;
    rst_ni       = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle tick, heading mode extremes incl. half-turn error
    add_tick(1'b0, 16'h1234, 16'h4321, 16'h0000);
    add_tick(1'b1, 16'h0000, 16'h0000, 16'h8000);
    add_tick(1'b0, 16'h0000, 16'h0000, 16'h8000);
    add_tick(1'b0, 16'h0000, 16'h0000, 16'hFFFF);
    add_tick(1'b0, 16'h0000, 16'h0000, 16'h0000);
    add_tick(1'b1, 16'h0000, 16'h0000, 16'h00B6);
    add_tick(1'b0, 16'h0000, 16'h0000, 16'h00B7);
    add_tick(1'b0, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // directed: position mode, goal equals pose, far extremes, near stop
    set_goal(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
    add_tick(1'b1, 16'h8000, 16'h7FFF, 16'h0000);
    add_tick(1'b1, 16'h7FFF, 16'h8000, 16'hFFFF);
    add_tick(1'b0, 16'h7FFF, 16'h7FFF, 16'h4000);
    add_tick(1'b0, 16'h8000, 16'h8000, 16'hC000);
    add_tick(1'b0, 16'h8000 + 16'd25, 16'h7FFF, 16'h8000);
    add_tick(1'b1, 16'h8000 + 16'd26, 16'h7FFF, 16'h8000);
    add_tick(1'b0, 16'h8000 + 16'd150, 16'h7FFF - 16'd100, 16'h2000);
    add_tick(1'b0, 16'h8000 + 16'd249, 16'h7FFF, 16'h7FFF);
    add_tick(1'b0, 16'h8000 + 16'd251, 16'h7FFF, 16'h0000);
    add_tick(1'b0, 16'h8000, 16'h7FFF, 16'h0000);
    add_tick(1'b0, 16'h8000, 16'h7FFF, 16'h0000);
    add_tick(1'b0, 16'h8000, 16'h7FFF, 16'h0000);
    drain();

    // random phases over several goals and both modes
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 1) gx = 16'sh7FFF;
      else if (ph == 2) gx = -16'sh8000;
      else gx = 16'($urandom_range(65535));
      gy = (ph == 2) ? 16'sh7FFF : 16'($urandom_range(65535));
      set_goal(gx, gy, 16'($urandom_range(65535)), ph[0] | (ph == 4));
      steady = (ph == 3);
      // receiver holds off so the block backs up against the sender
      if (ph == 5) hold_left = 400;
      add_tick(1'b1, gx + 16'd300, gy - 16'd200, 16'($urandom_range(65535)));
      random_ticks(100, gx, gy);
      drain();
    end
    steady = 1'b0;

    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end
endmodule

@@ go_to_goal_drive_controller.f @@
rtl/core/gtg_pkg.sv
rtl/core/gtg_if.sv
rtl/core/gtg_cordic.sv
rtl/core/gtg_isqrt.sv
rtl/core/go_to_goal_drive_controller.sv
bench/tb.sv
